@@ rtl/xtdr_pkg.sv @@
`default_nettype none
package xtdr_pkg;

  // Counter and bracket depth widths
  localparam int COUNT_BITS = 16;
  localparam int DEPTH_BITS = 8;

  typedef enum logic [2:0] {
    ST_MATCH   = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_NONE    = 3'd2,
    ST_BAD_XML = 3'd3,
    ST_BAD_DOC = 3'd4
  } status_t;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [DEPTH_BITS-1:0] depth_t;

  function automatic logic [7:0] mark_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    return 8'hEF;
      2'd1:    return 8'hBB;
      default: return 8'hBF;
    endcase
  endfunction

  function automatic logic [7:0] xml_word(input logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h3C; // <
      4'd1:    return 8'h3F; // ?
      4'd2:    return 8'h78; // x
      4'd3:    return 8'h6D; // m
      default: return 8'h6C; // l
    endcase
  endfunction

  function automatic logic [7:0] doc_word(input logic [3:0] idx);
    case (idx)
      4'd0:    return 8'h3C; // <
      4'd1:    return 8'h21; // !
      4'd2:    return 8'h44; // D
      4'd3:    return 8'h6F; // o
      4'd4:    return 8'h63; // c
      4'd5:    return 8'h74; // t
      4'd6:    return 8'h79; // y
      4'd7:    return 8'h70; // p
      default: return 8'h65; // e
    endcase
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_first(input logic [7:0] c);
    return is_letter(c) || (c == 8'h5F) || (c == 8'h3A);
  endfunction

  function automatic logic is_namec(input logic [7:0] c);
    return is_first(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h2D) || (c == 8'h2E);
  endfunction

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  // Output counts are 16 bits; larger counts show as all ones
  function automatic logic [15:0] clamp_out(input count_t v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/xml_top_declaration_recognizer.sv @@
// Recognizer for the top declaration of an XML document.
// Input channel: one document byte per request (data_byte) with last_byte
// marking the final byte; accepted when in_valid is high and in_stall low.
// Output channel: at most one request per document (status, decl_kind,
// lead_skip, decl_length); taken when out_valid is high and out_stall low.
// A leading byte-order mark and whitespace are skipped, then "<?xml ...?>"
// or "<!Doctype name ...>" is matched. The result is produced as soon as the
// outcome is known, or with the last byte; later bytes of that document are
// swallowed until last_byte, which returns the parser to its reset state.
// Latency: the result is registered and appears the cycle after the byte
// that decides it. Throughput: one byte per cycle while in_stall is low;
// the whole per-byte update is one pass of compares and a counter
// increment into the state registers. The output register frees the input
// side: a new byte is taken while the result is being handed over, and
// in_stall rises only when a result is held and out_stall is high.
// Reset (rst, synchronous) clears the parser state and drops any pending
// result.
`default_nettype none
module xml_top_declaration_recognizer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output xtdr_pkg::status_t      status,
  output logic                   decl_kind,
  output logic [15:0]            lead_skip,
  output logic [15:0]            decl_length
);
  import xtdr_pkg::*;

  typedef enum logic [3:0] {
    PH_MARK, PH_SPACE, PH_OPEN, PH_XML_TOKEN, PH_DOC_TOKEN,
    PH_XML_BODY, PH_DOC_NAME, PH_DOC_REST, PH_DONE
  } phase_t;

  typedef enum logic [1:0] { Q_NONE, Q_DOUBLE, Q_SINGLE } quote_t;
  typedef enum logic [1:0] { NP_WS, NP_GAP, NP_NAME } name_t;

  // parser state
  phase_t     phase, phase_next;
  logic [1:0] mark_index, mark_index_next;
  logic [3:0] token_index, token_index_next;
  logic       body_space_seen, body_space_seen_next;
  logic       prev_question, prev_question_next;
  quote_t     quote_mode, quote_mode_next;
  depth_t     bracket_depth, bracket_depth_next;
  name_t      name_phase, name_phase_next;
  count_t     skip_count, skip_count_next;
  count_t     length_count, length_count_next;

  // result of this byte
  logic       res_fire;
  status_t    res_status;
  logic       res_kind;
  logic       res_with_len;
  logic       do_space;
  logic       accept;

  // The output register is the only thing that can hold the input back
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    phase_next           = phase;
    mark_index_next      = mark_index;
    token_index_next     = token_index;
    body_space_seen_next = body_space_seen;
    prev_question_next   = prev_question;
    quote_mode_next      = quote_mode;
    bracket_depth_next   = bracket_depth;
    name_phase_next      = name_phase;
    skip_count_next      = skip_count;
    length_count_next    = length_count;
    res_fire             = 1'b0;
    res_status           = ST_NONE;
    res_kind             = 1'b0;
    res_with_len         = 1'b0;
    do_space             = 1'b0;

    if (phase == PH_MARK) begin
      if (mark_index != 2'd3 && data_byte == mark_byte(mark_index)) begin
        mark_index_next = mark_index + 2'd1;
        if (mark_index == 2'd2) begin
          skip_count_next = count_t'(3);
          phase_next      = PH_SPACE;
        end
      end else if (mark_index != 2'd0) begin
        // partial mark
        res_fire   = 1'b1;
        res_status = ST_NONE;
      end else begin
        phase_next = PH_SPACE;
        do_space   = 1'b1;
      end
    end else if (phase == PH_SPACE) begin
      do_space = 1'b1;
    end else if (phase != PH_DONE) begin
      length_count_next = sat_inc(length_count);
      case (phase)
        PH_OPEN: begin
          if (data_byte == xml_word(4'd1)) begin
            token_index_next = 4'd2;
            phase_next       = PH_XML_TOKEN;
          end else if (data_byte == doc_word(4'd1)) begin
            token_index_next = 4'd2;
            phase_next       = PH_DOC_TOKEN;
          end else begin
            res_fire   = 1'b1;
            res_status = ST_NONE;
          end
        end
        PH_XML_TOKEN: begin
          if (token_index >= 4'd5 || data_byte != xml_word(token_index)) begin
            res_fire   = 1'b1;
            res_status = ST_NONE;
          end else begin
            token_index_next = token_index + 4'd1;
            if (token_index == 4'd4) begin
              phase_next           = PH_XML_BODY;
              body_space_seen_next = 1'b0;
              prev_question_next   = 1'b0;
            end
          end
        end
        PH_DOC_TOKEN: begin
          if (token_index >= 4'd9 || data_byte != doc_word(token_index)) begin
            res_fire   = 1'b1;
            res_status = ST_NONE;
          end else begin
            token_index_next = token_index + 4'd1;
            if (token_index == 4'd8) begin
              phase_next      = PH_DOC_NAME;
              name_phase_next = NP_WS;
            end
          end
        end
        PH_XML_BODY: begin
          if (!body_space_seen) begin
            if (!is_ws(data_byte)) begin
              res_fire   = 1'b1;
              res_status = ST_BAD_XML;
            end else begin
              body_space_seen_next = 1'b1;
              prev_question_next   = 1'b0;
            end
          end else if (prev_question && data_byte == 8'h3E) begin
            res_fire     = 1'b1;
            res_status   = ST_MATCH;
            res_with_len = 1'b1;
          end else begin
            prev_question_next = (data_byte == 8'h3F);
          end
        end
        PH_DOC_NAME: begin
          case (name_phase)
            NP_WS: begin
              if (!is_ws(data_byte)) begin
                res_fire   = 1'b1;
                res_status = ST_BAD_DOC;
              end else begin
                name_phase_next = NP_GAP;
              end
            end
            NP_GAP: begin
              if (!is_ws(data_byte)) begin
                if (!is_first(data_byte)) begin
                  res_fire   = 1'b1;
                  res_status = ST_BAD_DOC;
                end else begin
                  name_phase_next = NP_NAME;
                end
              end
            end
            default: begin
              if (!is_namec(data_byte)) begin
                if (data_byte == 8'h3E) begin
                  res_fire     = 1'b1;
                  res_status   = ST_MATCH;
                  res_kind     = 1'b1;
                  res_with_len = 1'b1;
                end else if (!is_ws(data_byte)) begin
                  res_fire   = 1'b1;
                  res_status = ST_BAD_DOC;
                end else begin
                  quote_mode_next    = Q_NONE;
                  bracket_depth_next = '0;
                  phase_next         = PH_DOC_REST;
                end
              end
            end
          endcase
        end
        PH_DOC_REST: begin
          if (quote_mode != Q_NONE) begin
            if ((quote_mode == Q_DOUBLE && data_byte == 8'h22) ||
                (quote_mode == Q_SINGLE && data_byte == 8'h27)) begin
              quote_mode_next = Q_NONE;
            end
          end else if (data_byte == 8'h22) begin
            quote_mode_next = Q_DOUBLE;
          end else if (data_byte == 8'h27) begin
            quote_mode_next = Q_SINGLE;
          end else if (data_byte == 8'h5B) begin
            if (bracket_depth != '1) bracket_depth_next = bracket_depth + depth_t'(1);
          end else if (data_byte == 8'h5D) begin
            if (bracket_depth != '0) bracket_depth_next = bracket_depth - depth_t'(1);
          end else if (data_byte == 8'h3E && bracket_depth == '0) begin
            res_fire     = 1'b1;
            res_status   = ST_MATCH;
            res_kind     = 1'b1;
            res_with_len = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // whitespace skipping, also entered straight from the mark phase
    if (do_space) begin
      if (is_ws(data_byte)) begin
        skip_count_next = sat_inc(skip_count);
      end else if (data_byte != 8'h3C) begin
        res_fire   = 1'b1;
        res_status = ST_NONE;
      end else begin
        length_count_next = count_t'(1);
        token_index_next  = 4'd1;
        phase_next        = PH_OPEN;
      end
    end

    if (res_fire) phase_next = PH_DONE;

    // end of document: report if still undecided
    if (last_byte && phase != PH_DONE && !res_fire) begin
      res_fire     = 1'b1;
      res_kind     = 1'b0;
      res_with_len = 1'b0;
      case (phase_next)
        PH_MARK:     res_status = (mark_index_next != 2'd0) ? ST_NONE : ST_EMPTY;
        PH_SPACE:    res_status = ST_EMPTY;
        PH_XML_BODY: res_status = ST_BAD_XML;
        PH_DOC_NAME,
        PH_DOC_REST: res_status = ST_BAD_DOC;
        default:     res_status = ST_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MARK;
      mark_index      <= 2'd0;
      token_index     <= 4'd0;
      body_space_seen <= 1'b0;
      prev_question   <= 1'b0;
      quote_mode      <= Q_NONE;
      bracket_depth   <= '0;
      name_phase      <= NP_WS;
      skip_count      <= '0;
      length_count    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          phase           <= PH_MARK;
          mark_index      <= 2'd0;
          token_index     <= 4'd0;
          body_space_seen <= 1'b0;
          prev_question   <= 1'b0;
          quote_mode      <= Q_NONE;
          bracket_depth   <= '0;
          name_phase      <= NP_WS;
          skip_count      <= '0;
          length_count    <= '0;
        end else begin
          phase           <= phase_next;
          mark_index      <= mark_index_next;
          token_index     <= token_index_next;
          body_space_seen <= body_space_seen_next;
          prev_question   <= prev_question_next;
          quote_mode      <= quote_mode_next;
          bracket_depth   <= bracket_depth_next;
          name_phase      <= name_phase_next;
          skip_count      <= skip_count_next;
          length_count    <= length_count_next;
        end
      end
      if (accept && res_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a new result is taken in
  always_ff @(posedge clk) begin
    if (accept && res_fire) begin
      status      <= res_status;
      decl_kind   <= res_kind;
      lead_skip   <= clamp_out(skip_count_next);
      decl_length <= res_with_len ? clamp_out(length_count_next) : 16'd0;
    end
  end

  // last byte always brings the parser back to its start
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> phase == PH_MARK && skip_count == '0 && mark_index == 2'd0)
    else $error("parser not reset after last byte");

  // a match carries a length, anything else does not
  a_len_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_MATCH) == (decl_length != 16'd0)))
    else $error("declaration length inconsistent with status");

  a_kind_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && decl_kind |-> status == ST_MATCH)
    else $error("doctype kind without a match");

  // once decided mid-document, the parser stays quiet
  a_decided: assert property (@(posedge clk) disable iff (rst)
    accept && res_fire && !last_byte |=> phase == PH_DONE && out_valid)
    else $error("decision not recorded");

endmodule
`default_nettype wire
